// File: design/bpfm_pkg.sv
// shared types and constants of the buffer pool frame manager
package bpfm_pkg;

  localparam int FRAMES  = 16;
  localparam int IDX_W   = 4;
  localparam int NACT_W  = 5;
  localparam int PAGE_W  = 24;
  localparam int STAMP_W = 32;
  localparam int PIN_W   = 8;
  localparam int CNT_W   = 32;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    FN_PIN   = 3'd0,
    FN_UNPIN = 3'd1,
    FN_DIRTY = 3'd2,
    FN_FORCE = 3'd3,
    FN_FLUSH = 3'd4,
    FN_QUERY = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOTFND  = 3'd1,
    ST_NOTPIN  = 3'd2,
    ST_NOFREE  = 3'd3,
    ST_PINOVF  = 3'd4,
    ST_EMPTY   = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY = 2'd0,
    CFG_FRAMES = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LRU,
    S_REPL,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic load;
    logic inc;
    logic dec;
    logic set_dirty;
    logic clr_dirty;
    logic stamp_we;
  } cell_cmd_t;

  typedef struct packed {
    logic               valid;
    logic               dirty;
    logic [PIN_W-1:0]   pin;
    logic [PAGE_W-1:0]  tag;
    logic [STAMP_W-1:0] stamp;
  } cell_view_t;

endpackage

// File: design/bpfm_cell.sv
// one frame of the table: tag, flags, pin count, use stamp and match chain link
module bpfm_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [bpfm_pkg::PAGE_W-1:0]  page_i,
  input  logic [bpfm_pkg::STAMP_W-1:0] stamp_i,
  input  bpfm_pkg::cell_cmd_t          cmd_i,
  input  logic                        found_i,
  output logic                        found_o,
  output logic                        hit_o,
  output bpfm_pkg::cell_view_t         view_o
);
  import bpfm_pkg::*;

  logic               valid_q, dirty_q;
  logic [PIN_W-1:0]   pin_q;
  logic [PAGE_W-1:0]  tag_q;
  logic [STAMP_W-1:0] stamp_q;
  logic               match;

  assign match   = en_i & valid_q & (tag_q == page_i);
  assign hit_o   = match & ~found_i;
  assign found_o = found_i | match;

  assign view_o = '{valid: valid_q, dirty: dirty_q, pin: pin_q, tag: tag_q, stamp: stamp_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      pin_q   <= '0;
      stamp_q <= '0;
    end else begin
      if (cmd_i.load) begin
        valid_q <= 1'b1;
        dirty_q <= 1'b0;
        pin_q   <= PIN_W'(1);
      end else begin
        if (cmd_i.inc) pin_q <= pin_q + PIN_W'(1);
        if (cmd_i.dec) pin_q <= pin_q - PIN_W'(1);
        if (cmd_i.set_dirty) dirty_q <= 1'b1;
        if (cmd_i.clr_dirty) dirty_q <= 1'b0;
      end
      if (cmd_i.stamp_we) stamp_q <= stamp_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) tag_q <= page_i;
  end

endmodule

// File: design/buffer_pool_frame_manager_core.sv
// buffer pool frame manager: row of frame cells, request sequencer and result register
//
// channel | direction | handshake                | payload
// in      | into      | in_valid_i / in_stall_o  | func_i, page_num_i, frame_sel_i
// out     | out of    | out_valid_o / out_stall_i| status_o .. last_o
// cfg     | into      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// one request at a time; the lookup across the active cells is combinational, so pin hit,
// unpin, dirty, force, query and a FIFO miss finish in the execute state
// an LRU miss walks the active frames one per cycle
// flush all scans a frame per cycle unless stalled, one result per dirty unpinned frame
// reset clears all flags, counts, stamps and the FIFO order at once
// a stalled result holds the sequencer when a new result is due and when a request starts
module buffer_pool_frame_manager_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    func_i,
  input  logic [bpfm_pkg::PAGE_W-1:0]   page_num_i,
  input  logic [bpfm_pkg::IDX_W-1:0]    frame_sel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [bpfm_pkg::IDX_W-1:0]    frame_o,
  output logic                          hit_o,
  output logic                          writeback_o,
  output logic [bpfm_pkg::PAGE_W-1:0]   page_out_o,
  output logic                          load_o,
  output logic                          dirty_o,
  output logic [bpfm_pkg::PIN_W-1:0]    fix_count_o,
  output logic [bpfm_pkg::CNT_W-1:0]    read_count_o,
  output logic [bpfm_pkg::CNT_W-1:0]    write_count_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bpfm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bpfm_pkg::NACT_W-1:0]   cfg_data_i
);
  import bpfm_pkg::*;

  state_e state_q, state_d;

  logic [2:0]         func_q;
  logic [PAGE_W-1:0]  page_q;
  logic [IDX_W-1:0]   sel_q;
  logic               policy_q;
  logic [NACT_W-1:0]  fiu_q;
  logic [IDX_W-1:0]   order_q [FRAMES];
  logic [IDX_W-1:0]   order_d [FRAMES];
  logic [STAMP_W-1:0] stamp_q, stamp_d;
  logic [CNT_W-1:0]   loads_q, loads_d, writes_q, writes_d;
  logic [IDX_W-1:0]   scan_q, scan_d;
  logic               best_v_q, best_v_d;
  logic [IDX_W-1:0]   best_q, best_d;

  cell_cmd_t  cmd [FRAMES];
  cell_view_t cv  [FRAMES];
  logic [FRAMES:0]   found;
  logic [FRAMES-1:0] hitv, en, fmask, above;

  logic [NACT_W-1:0] nact;
  logic [IDX_W-1:0]  nact_m1;
  logic              any_hit;
  logic [IDX_W-1:0]  hit_idx;
  logic              fv_found;
  logic [IDX_W-1:0]  fv_pos, fv_idx;

  logic              can_emit, emit;
  logic [2:0]        e_status;
  logic [IDX_W-1:0]  e_frame;
  logic              e_hit, e_wb, e_load, e_dirty, e_last;
  logic [PAGE_W-1:0] e_page;
  logic [PIN_W-1:0]  e_fix;

  logic              do_repl, do_touch, wr_inc, fifo_shift;
  logic [IDX_W-1:0]  repl_idx, touch_idx;
  cell_view_t        vu, vs, vr;

  logic              out_valid_q;
  logic [2:0]        status_q;
  logic [IDX_W-1:0]  frame_q;
  logic              hit_q, wb_q, load_q, dirty_q, last_q;
  logic [PAGE_W-1:0] page_out_q;
  logic [PIN_W-1:0]  fix_q;
  logic [CNT_W-1:0]  rd_cnt_q, wr_cnt_q;

  assign nact = (fiu_q == '0) ? NACT_W'(1) :
                (fiu_q > NACT_W'(FRAMES)) ? NACT_W'(FRAMES) : fiu_q;
  assign nact_m1 = IDX_W'(nact - NACT_W'(1));

  assign found[0] = 1'b0;
  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    assign en[g]    = (NACT_W'(g) < nact);
    assign fmask[g] = en[g] & cv[g].valid & cv[g].dirty & (cv[g].pin == '0);
    assign above[g] = (IDX_W'(g) > scan_q);
    bpfm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[g]),
      .page_i  (page_q),
      .stamp_i (stamp_q + STAMP_W'(1)),
      .cmd_i   (cmd[g]),
      .found_i (found[g]),
      .found_o (found[g+1]),
      .hit_o   (hitv[g]),
      .view_o  (cv[g])
    );
  end

  assign any_hit = found[FRAMES];

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (hitv[i]) hit_idx = IDX_W'(i);
    end
  end

  // first unpinned frame in fifo order
  always_comb begin
    fv_found = 1'b0;
    fv_pos   = '0;
    fv_idx   = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (!fv_found && en[i] && (cv[order_q[i]].pin == '0)) begin
        fv_found = 1'b1;
        fv_pos   = IDX_W'(i);
        fv_idx   = order_q[i];
      end
    end
  end

  assign vu = cv[hit_idx];
  assign vs = cv[sel_q];
  assign vr = cv[repl_idx];

  assign can_emit    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    best_v_d   = best_v_q;
    best_d     = best_q;
    emit       = 1'b0;
    e_status   = ST_OK;
    e_frame    = '0;
    e_hit      = 1'b0;
    e_wb       = 1'b0;
    e_page     = '0;
    e_load     = 1'b0;
    e_dirty    = 1'b0;
    e_fix      = '0;
    e_last     = 1'b1;
    do_repl    = 1'b0;
    repl_idx   = '0;
    do_touch   = 1'b0;
    touch_idx  = '0;
    wr_inc     = 1'b0;
    fifo_shift = 1'b0;
    for (int i = 0; i < FRAMES; i++) cmd[i] = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (can_emit) begin
          state_d = S_IDLE;
          case (func_q)
            FN_PIN: begin
              if (any_hit) begin
                emit    = 1'b1;
                e_frame = hit_idx;
                e_hit   = 1'b1;
                e_dirty = vu.dirty;
                if (vu.pin == '1) begin
                  e_status = ST_PINOVF;
                  e_fix    = vu.pin;
                end else begin
                  cmd[hit_idx].inc = 1'b1;
                  do_touch  = policy_q;
                  touch_idx = hit_idx;
                  e_fix     = vu.pin + PIN_W'(1);
                end
              end else if (!policy_q) begin
                if (fv_found) begin
                  do_repl    = 1'b1;
                  repl_idx   = fv_idx;
                  fifo_shift = 1'b1;
                end else begin
                  emit     = 1'b1;
                  e_status = ST_NOFREE;
                end
              end else begin
                state_d  = S_LRU;
                scan_d   = '0;
                best_v_d = 1'b0;
              end
            end
            FN_UNPIN, FN_DIRTY, FN_FORCE: begin
              emit = 1'b1;
              if (!any_hit) begin
                e_status = ST_NOTFND;
              end else begin
                e_frame = hit_idx;
                e_dirty = vu.dirty;
                e_fix   = vu.pin;
                if (func_q == FN_UNPIN) begin
                  if (vu.pin == '0) begin
                    e_status = ST_NOTPIN;
                  end else begin
                    cmd[hit_idx].dec = 1'b1;
                    do_touch  = policy_q;
                    touch_idx = hit_idx;
                    e_fix     = vu.pin - PIN_W'(1);
                  end
                end else if (func_q == FN_DIRTY) begin
                  cmd[hit_idx].set_dirty = 1'b1;
                  e_dirty = 1'b1;
                end else if (vu.dirty) begin
                  cmd[hit_idx].clr_dirty = 1'b1;
                  e_dirty = 1'b0;
                  e_wb    = 1'b1;
                  e_page  = vu.tag;
                  wr_inc  = 1'b1;
                end
              end
            end
            FN_FLUSH: begin
              if (fmask == '0) begin
                emit = 1'b1;
              end else begin
                state_d = S_FLUSH;
                scan_d  = '0;
              end
            end
            FN_QUERY: begin
              emit    = 1'b1;
              e_frame = sel_q;
              if ((NACT_W'(sel_q) >= nact) || !vs.valid) begin
                e_status = ST_EMPTY;
              end else begin
                e_page  = vs.tag;
                e_dirty = vs.dirty;
                e_fix   = vs.pin;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_LRU: begin
        if (en[scan_q] && (cv[scan_q].pin == '0) &&
            (!best_v_q || (cv[scan_q].stamp < cv[best_q].stamp))) begin
          best_v_d = 1'b1;
          best_d   = scan_q;
        end
        if (scan_q == nact_m1) state_d = S_REPL;
        else scan_d = scan_q + IDX_W'(1);
      end
      S_REPL: begin
        if (can_emit) begin
          state_d = S_IDLE;
          if (best_v_q) begin
            do_repl  = 1'b1;
            repl_idx = best_q;
          end else begin
            emit     = 1'b1;
            e_status = ST_NOFREE;
          end
        end
      end
      S_FLUSH: begin
        if (fmask[scan_q]) begin
          if (can_emit) begin
            emit    = 1'b1;
            e_frame = scan_q;
            e_wb    = 1'b1;
            e_page  = cv[scan_q].tag;
            e_last  = ((fmask & above) == '0);
            wr_inc  = 1'b1;
            cmd[scan_q].clr_dirty = 1'b1;
            if (e_last) state_d = S_IDLE;
            else scan_d = scan_q + IDX_W'(1);
          end
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // victim replacement shared by fifo and lru misses
    if (do_repl) begin
      emit    = 1'b1;
      e_frame = repl_idx;
      e_load  = 1'b1;
      e_fix   = PIN_W'(1);
      e_wb    = vr.valid & vr.dirty;
      e_page  = (vr.valid & vr.dirty) ? vr.tag : '0;
      wr_inc  = vr.valid & vr.dirty;
      cmd[repl_idx].load = 1'b1;
      do_touch  = policy_q;
      touch_idx = repl_idx;
    end
    if (do_touch) cmd[touch_idx].stamp_we = 1'b1;
  end

  assign stamp_d  = do_touch ? stamp_q + STAMP_W'(1) : stamp_q;
  assign loads_d  = do_repl ? loads_q + CNT_W'(1) : loads_q;
  assign writes_d = wr_inc ? writes_q + CNT_W'(1) : writes_q;

  always_comb begin
    for (int j = 0; j < FRAMES; j++) order_d[j] = order_q[j];
    if (cfg_valid_i && cfg_index_i == CFG_FRAMES) begin
      for (int j = 0; j < FRAMES; j++) order_d[j] = IDX_W'(j);
    end else if (fifo_shift) begin
      for (int j = 0; j < FRAMES - 1; j++) begin
        if (IDX_W'(j) >= fv_pos && IDX_W'(j) < nact_m1) order_d[j] = order_q[j+1];
      end
      order_d[nact_m1] = fv_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      scan_q   <= '0;
      best_v_q <= 1'b0;
      best_q   <= '0;
      policy_q <= 1'b0;
      fiu_q    <= NACT_W'(FRAMES);
      stamp_q  <= '0;
      loads_q  <= '0;
      writes_q <= '0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < FRAMES; j++) order_q[j] <= IDX_W'(j);
    end else begin
      state_q  <= state_d;
      scan_q   <= scan_d;
      best_v_q <= best_v_d;
      best_q   <= best_d;
      stamp_q  <= stamp_d;
      loads_q  <= loads_d;
      writes_q <= writes_d;
      order_q  <= order_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_POLICY) policy_q <= cfg_data_i[0];
        if (cfg_index_i == CFG_FRAMES) fiu_q <= cfg_data_i;
      end
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      func_q <= func_i;
      page_q <= page_num_i;
      sel_q  <= frame_sel_i;
    end
    if (emit) begin
      status_q   <= e_status;
      frame_q    <= e_frame;
      hit_q      <= e_hit;
      wb_q       <= e_wb;
      page_out_q <= e_page;
      load_q     <= e_load;
      dirty_q    <= e_dirty;
      fix_q      <= e_fix;
      rd_cnt_q   <= loads_d;
      wr_cnt_q   <= writes_d;
      last_q     <= e_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign frame_o       = frame_q;
  assign hit_o         = hit_q;
  assign writeback_o   = wb_q;
  assign page_out_o    = page_out_q;
  assign load_o        = load_q;
  assign dirty_o       = dirty_q;
  assign fix_count_o   = fix_q;
  assign read_count_o  = rd_cnt_q;
  assign write_count_o = wr_cnt_q;
  assign last_o        = last_q;

  // at most one cell claims the first match
  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(hitv))
    else $error("several cells report the first match");

  // a result is only produced while a request is in flight
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (state_q != S_IDLE))
    else $error("result produced while idle");

  // the write-back total moves only together with a write-back result
  a_wr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (writes_q != $past(writes_q)) |-> $past(emit && e_wb))
    else $error("write-back total moved without a write-back");

  // a new result never overwrites one that is still stalled
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !emit)
    else $error("stalled result overwritten");

endmodule

// File: tb/sv/tb_buffer_pool_frame_manager_core.sv
// self-checking testbench of the buffer pool frame manager core
module tb_buffer_pool_frame_manager_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bpfm_pkg::*;

  localparam logic [2:0] FN_RSVD_LO = 3'd6;
  localparam logic [2:0] FN_RSVD_HI = 3'd7;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [2:0]        func;
    logic [PAGE_W-1:0] page;
    logic [IDX_W-1:0]  sel;
  } request_t;

  typedef struct {
    logic [2:0]        status;
    logic [IDX_W-1:0]  frame;
    logic              hit;
    logic              writeback;
    logic [PAGE_W-1:0] page_out;
    logic              load;
    logic              dirty;
    logic [PIN_W-1:0]  fix_count;
    logic [CNT_W-1:0]  read_count;
    logic [CNT_W-1:0]  write_count;
    logic              last;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] func_i = '0;
  logic [PAGE_W-1:0] page_num_i = '0;
  logic [IDX_W-1:0] frame_sel_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [IDX_W-1:0] frame_o;
  logic hit_o, writeback_o, load_o, dirty_o, last_o;
  logic [PAGE_W-1:0] page_out_o;
  logic [PIN_W-1:0] fix_count_o;
  logic [CNT_W-1:0] read_count_o, write_count_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_POLICY;
  logic [NACT_W-1:0] cfg_data_i = '0;

  buffer_pool_frame_manager_core i_dut (.*);

  // model of the frame table
  logic [PAGE_W-1:0]  pool_tag   [FRAMES];
  logic               pool_valid [FRAMES];
  logic               pool_dirty [FRAMES];
  logic [PIN_W-1:0]   pool_pins  [FRAMES];
  logic [IDX_W-1:0]   pool_order [FRAMES];
  logic [STAMP_W-1:0] pool_stamp [FRAMES];
  logic [STAMP_W-1:0] stamp_now;
  logic [CNT_W-1:0]   loads_done, writes_done;
  logic               use_lru;
  logic [NACT_W-1:0]  pool_size;

  request_t pending_requests[$];
  answer_t  awaited_answers[$];
  int n_sent = 0, n_accepted = 0;
  int gap_left = 0, stall_left = 0;
  bit quiet = 0, failed = 0;
  int cycles = 0;
  logic [PAGE_W-1:0] hot_pages[16];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int active_count();
    if (pool_size < 1) return 1;
    if (pool_size > FRAMES) return FRAMES;
    return pool_size;
  endfunction

  function automatic void reset_order();
    for (int i = 0; i < FRAMES; i++) pool_order[i] = IDX_W'(i);
  endfunction

  function automatic void bump_stamp(int f);
    if (use_lru) begin
      stamp_now++;
      pool_stamp[f] = stamp_now;
    end
  endfunction

  function automatic answer_t make_answer(logic [2:0] st, int fr, logic h, logic wb,
                                          logic [PAGE_W-1:0] pg, logic ld, logic dt,
                                          logic [PIN_W-1:0] fix, logic lst);
    answer_t a;
    a.status = st; a.frame = IDX_W'(fr); a.hit = h; a.writeback = wb; a.page_out = pg;
    a.load = ld; a.dirty = dt; a.fix_count = fix;
    a.read_count = loads_done; a.write_count = writes_done; a.last = lst;
    return a;
  endfunction

  function automatic int choose_victim(int n);
    int best;
    best = -1;
    if (!use_lru) begin
      for (int i = 0; i < n; i++) begin
        int f;
        f = pool_order[i];
        if (pool_pins[f] == 0) begin
          for (int j = i; j + 1 < n; j++) pool_order[j] = pool_order[j + 1];
          pool_order[n - 1] = IDX_W'(f);
          return f;
        end
      end
      return -1;
    end
    for (int i = 0; i < n; i++)
      if (pool_pins[i] == 0 && (best < 0 || pool_stamp[i] < pool_stamp[best])) best = i;
    return best;
  endfunction

  function automatic void predict_request(request_t r);
    int n, f, v;
    logic wb;
    logic [PAGE_W-1:0] old;
    logic [2:0] st;
    answer_t flushed[$];
    n = active_count();
    f = -1;
    if (r.func <= FN_FORCE)
      for (int i = n - 1; i >= 0; i--)
        if (pool_valid[i] && pool_tag[i] == r.page) f = i;
    case (r.func)
      FN_PIN: begin
        if (f >= 0) begin
          if (pool_pins[f] == 8'd255) begin
            awaited_answers.push_back(make_answer(ST_PINOVF, f, 1, 0, 0, 0,
                                                  pool_dirty[f], pool_pins[f], 1));
          end else begin
            pool_pins[f]++;
            bump_stamp(f);
            awaited_answers.push_back(make_answer(ST_OK, f, 1, 0, 0, 0,
                                                  pool_dirty[f], pool_pins[f], 1));
          end
        end else begin
          v = choose_victim(n);
          if (v < 0) begin
            awaited_answers.push_back(make_answer(ST_NOFREE, 0, 0, 0, 0, 0, 0, 0, 1));
          end else begin
            wb = pool_valid[v] && pool_dirty[v];
            old = wb ? pool_tag[v] : '0;
            if (wb) writes_done++;
            pool_tag[v] = r.page;
            pool_valid[v] = 1;
            pool_pins[v] = 1;
            pool_dirty[v] = 0;
            loads_done++;
            bump_stamp(v);
            awaited_answers.push_back(make_answer(ST_OK, v, 0, wb, old, 1, 0, 1, 1));
          end
        end
      end
      FN_UNPIN, FN_DIRTY, FN_FORCE: begin
        if (f < 0) begin
          awaited_answers.push_back(make_answer(ST_NOTFND, 0, 0, 0, 0, 0, 0, 0, 1));
        end else begin
          st = ST_OK; wb = 0; old = '0;
          if (r.func == FN_UNPIN) begin
            if (pool_pins[f] == 0) st = ST_NOTPIN;
            else begin
              pool_pins[f]--;
              bump_stamp(f);
            end
          end else if (r.func == FN_DIRTY) begin
            pool_dirty[f] = 1;
          end else if (pool_dirty[f]) begin
            wb = 1; old = pool_tag[f]; pool_dirty[f] = 0; writes_done++;
          end
          awaited_answers.push_back(make_answer(st, f, 0, wb, old, 0,
                                                pool_dirty[f], pool_pins[f], 1));
        end
      end
      FN_FLUSH: begin
        for (int i = 0; i < n; i++) begin
          if (pool_valid[i] && pool_dirty[i] && pool_pins[i] == 0) begin
            pool_dirty[i] = 0;
            writes_done++;
            flushed.push_back(make_answer(ST_OK, i, 0, 1, pool_tag[i], 0, 0, 0, 0));
          end
        end
        if (flushed.size() == 0)
          flushed.push_back(make_answer(ST_OK, 0, 0, 0, 0, 0, 0, 0, 0));
        flushed[flushed.size() - 1].last = 1;
        foreach (flushed[k]) awaited_answers.push_back(flushed[k]);
      end
      FN_QUERY: begin
        if (r.sel >= n || !pool_valid[r.sel])
          awaited_answers.push_back(make_answer(ST_EMPTY, r.sel, 0, 0, 0, 0, 0, 0, 1));
        else
          awaited_answers.push_back(make_answer(ST_OK, r.sel, 0, 0, pool_tag[r.sel], 0,
                                                pool_dirty[r.sel], pool_pins[r.sel], 1));
      end
      default: awaited_answers.push_back(make_answer(ST_OK, 0, 0, 0, 0, 0, 0, 0, 1));
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      failed = 1;
    end
  endfunction

  // request driver: a request still waiting for its transfer is held
  always @(negedge clk_i) begin
    if (!(in_valid_i && n_accepted != n_sent)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        request_t r;
        r = pending_requests.pop_front();
        func_i <= r.func;
        page_num_i <= r.page;
        frame_sel_i <= r.sel;
        in_valid_i <= 1'b1;
        n_sent <= n_sent + 1;
        if (!quiet && $urandom_range(0, 4) == 0) gap_left <= $urandom_range(1, 3);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result stall
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // request acceptance and result checking
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      request_t r;
      r.func = func_i; r.page = page_num_i; r.sel = frame_sel_i;
      predict_request(r);
      n_accepted <= n_accepted + 1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_answers.size() == 0) begin
        $error("result transfer with no result expected");
        failed = 1;
      end else begin
        answer_t a;
        a = awaited_answers.pop_front();
        check_field("status", a.status, status_o);
        check_field("frame", a.frame, frame_o);
        check_field("hit", a.hit, hit_o);
        check_field("writeback", a.writeback, writeback_o);
        check_field("page_out", a.page_out, page_out_o);
        check_field("load", a.load, load_o);
        check_field("dirty", a.dirty, dirty_o);
        check_field("fix_count", a.fix_count, fix_count_o);
        check_field("read_count", a.read_count, read_count_o);
        check_field("write_count", a.write_count, write_count_o);
        check_field("last", a.last, last_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_request(logic [2:0] fn, logic [PAGE_W-1:0] pg, logic [IDX_W-1:0] sel);
    request_t r;
    r.func = fn; r.page = pg; r.sel = sel;
    pending_requests.push_back(r);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_requests.size() > 0 || n_sent != n_accepted || in_valid_i ||
           awaited_answers.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [NACT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    if (idx == CFG_POLICY) use_lru = data[0];
    else begin
      pool_size = data;
      reset_order();
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic push_random(int count);
    logic [2:0] fn;
    logic [PAGE_W-1:0] pg;
    int w;
    for (int k = 0; k < count; k++) begin
      w = $urandom_range(0, 99);
      if (w < 35) fn = FN_PIN;
      else if (w < 60) fn = FN_UNPIN;
      else if (w < 72) fn = FN_DIRTY;
      else if (w < 80) fn = FN_FORCE;
      else if (w < 85) fn = FN_FLUSH;
      else if (w < 97) fn = FN_QUERY;
      else fn = $urandom_range(0, 1) ? FN_RSVD_LO : FN_RSVD_HI;
      // mostly a small working set so that hits and evictions happen
      pg = ($urandom_range(0, 9) == 0) ? PAGE_W'($urandom) : hot_pages[$urandom_range(0, 15)];
      push_request(fn, pg, $urandom_range(0, 15));
    end
  endtask

  initial begin
    for (int i = 0; i < FRAMES; i++) begin
      pool_valid[i] = 0; pool_dirty[i] = 0; pool_pins[i] = 0; pool_stamp[i] = 0;
      pool_tag[i] = '0;
    end
    reset_order();
    stamp_now = 0; loads_done = 0; writes_done = 0; use_lru = 0; pool_size = 16;
    hot_pages[0] = '0;
    hot_pages[1] = '1;
    for (int i = 2; i < 16; i++) hot_pages[i] = PAGE_W'($urandom);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: corners of each request kind
    push_request(FN_QUERY, 0, 0);
    push_request(FN_QUERY, 0, 15);
    push_request(FN_UNPIN, '1, 0);
    push_request(FN_FORCE, 0, 0);
    push_request(FN_PIN, 0, 0);
    push_request(FN_PIN, '1, 0);
    push_request(FN_PIN, 0, 0);
    push_request(FN_DIRTY, 0, 0);
    push_request(FN_FORCE, 0, 0);
    push_request(FN_FORCE, 0, 0);
    push_request(FN_UNPIN, 0, 0);
    push_request(FN_UNPIN, 0, 0);
    push_request(FN_UNPIN, 0, 0);
    push_request(FN_DIRTY, 0, 0);
    push_request(FN_DIRTY, '1, 0);
    push_request(FN_FLUSH, 0, 0);
    push_request(FN_FLUSH, 0, 0);
    push_request(FN_QUERY, 0, 0);
    push_request(FN_QUERY, 0, 1);
    push_request(FN_RSVD_LO, '1, 15);
    push_request(FN_RSVD_HI, 0, 0);
    wait_idle();

    write_reg(CFG_POLICY, 1);
    write_reg(CFG_FRAMES, 4);
    push_random(60);
    wait_idle();

    // a single frame: misses while it is pinned find no free frame
    write_reg(CFG_POLICY, 0);
    write_reg(CFG_FRAMES, 0);
    push_random(30);
    wait_idle();

    // pin count saturation, then random under LRU over all frames
    // the saturated page stays pinned for the rest of the run
    write_reg(CFG_POLICY, 1);
    write_reg(CFG_FRAMES, 31);
    for (int i = 0; i < 256; i++) push_request(FN_PIN, 24'h00a5a5, 0);
    push_request(FN_UNPIN, 24'h00a5a5, 0);
    push_request(FN_PIN, 24'h00a5a5, 0);
    push_request(FN_PIN, 24'h00a5a5, 0);
    push_random(30);
    wait_idle();

    write_reg(CFG_POLICY, 0);
    write_reg(CFG_FRAMES, 16);
    push_random(10);
    wait_idle();
    quiet = 1;
    push_random(15);
    wait_idle();

    if (failed) $display("tb: failure");
    else $display("tb: success");
    $finish;
  end

endmodule
